[rtl/mbtr_pkg.sv]
// Shared types and constants of the Modbus TCP read register responder.
package mbtr_pkg;

  localparam int WORD_W     = 16;
  localparam int QTY_W      = 7;
  localparam int FRAME_KEEP = 12;
  localparam int SEEN_W     = 4;

  localparam logic [15:0] BASE_ADDRESS_RESET = 16'd40000;

  localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FC_EXC_FLAG      = 8'h80;
  localparam logic [7:0] EXC_BAD_FUNCTION = 8'd0;
  localparam logic [7:0] EXC_BAD_ADDRESS  = 8'd1;
  localparam logic [7:0] MBAP_LEN_EXC     = 8'd3;

  localparam logic CMD_REQUEST_BYTE = 1'b0;
  localparam logic CMD_WRITE_WORD   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_JUDGE,
    ST_HEADER,
    ST_DATA
  } ctrl_state_t;

  // Outcome of checking a complete request frame.
  typedef struct packed {
    logic             drop;
    logic             bad_function;
    logic             bad_address;
    logic [15:0]      tid;
    logic [7:0]       unit_id;
    logic [7:0]       fc;
    logic [QTY_W-1:0] qty;
  } verdict_t;

endpackage

[rtl/mbtr_image_ram.sv]
// Register image memory with one write port and two registered read ports.
module mbtr_image_ram import mbtr_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr0,
  input  logic [AW-1:0]     raddr1,
  output logic [WORD_W-1:0] rdata0,
  output logic [WORD_W-1:0] rdata1
);

  logic [WORD_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds between reads, so it can drive an output directly.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

[rtl/mbtr_frame_judge.sv]
// Request byte capture and frame checking for the read register responder.
module mbtr_frame_judge import mbtr_pkg::*; #(
  parameter int IMAGE_WORDS = 256,
  parameter int MAX_QUANTITY = 125,
  localparam int AW = $clog2(IMAGE_WORDS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_accept,
  input  logic [7:0]    request_byte,
  input  logic          frame_end,
  input  logic [15:0]   base_address,
  input  logic [16:0]   base_end,
  output logic          frame_complete,
  output verdict_t      verdict,
  output logic [AW-1:0] start_idx
);

  logic [SEEN_W-1:0] bytes_seen;
  logic [7:0]        req_bytes [0:FRAME_KEEP-1];
  logic [15:0]       proto;
  logic [15:0]       start;
  logic [15:0]       qty;
  logic [16:0]       range_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (byte_accept) begin
      if (frame_end) begin
        bytes_seen <= '0;
      end else if (bytes_seen < SEEN_W'(FRAME_KEEP)) begin
        bytes_seen <= bytes_seen + 1'b1;
      end
    end
  end

  // Bytes past the twelfth are not kept.
  always_ff @(posedge clk) begin
    if (byte_accept && bytes_seen < SEEN_W'(FRAME_KEEP)) begin
      req_bytes[bytes_seen] <= request_byte;
    end
  end

  // The byte now arriving fills the last kept slot or comes later.
  assign frame_complete = (bytes_seen >= SEEN_W'(FRAME_KEEP - 1));

  assign proto     = {req_bytes[2], req_bytes[3]};
  assign start     = {req_bytes[8], req_bytes[9]};
  assign qty       = {req_bytes[10], req_bytes[11]};
  assign range_end = {1'b0, start} + {1'b0, qty};

  always_comb begin
    verdict.drop         = (proto != 16'd0);
    verdict.bad_function = (req_bytes[7] != FC_READ_HOLDING);
    verdict.bad_address  = (qty == 16'd0) || (qty > 16'(MAX_QUANTITY)) ||
                           (start < base_address) || (range_end > base_end);
    verdict.tid          = {req_bytes[0], req_bytes[1]};
    verdict.unit_id      = req_bytes[6];
    verdict.fc           = req_bytes[7];
    verdict.qty          = qty[QTY_W-1:0];
  end

  assign start_idx = AW'(start - base_address);

endmodule

[rtl/mbtr_ctrl.sv]
// Sequencer of the responder: image clearing, writes, judging and readout.
module mbtr_ctrl import mbtr_pkg::*; #(
  parameter int IMAGE_WORDS = 256,
  localparam int AW = $clog2(IMAGE_WORDS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic              frame_end,
  input  logic [7:0]        write_index,
  input  logic [15:0]       write_value,
  input  logic              frame_complete,
  input  verdict_t          verdict,
  input  logic [AW-1:0]     start_idx,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              is_header,
  output logic [15:0]       trans_id,
  output logic [7:0]        mbap_length,
  output logic [7:0]        unit_id,
  output logic [7:0]        function_code,
  output logic [7:0]        count_or_exception,
  output logic [15:0]       word_first,
  output logic [15:0]       word_second,
  output logic [1:0]        words_valid,
  output logic              last,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [WORD_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr0,
  output logic [AW-1:0]     ram_raddr1,
  input  logic [WORD_W-1:0] ram_rdata0,
  input  logic [WORD_W-1:0] ram_rdata1
);

  ctrl_state_t      state, state_next;
  logic [AW-1:0]    clr_cnt;
  logic [AW-1:0]    rd_idx;
  logic [QTY_W-1:0] rem;
  logic [15:0]      hdr_tid;
  logic [7:0]       hdr_len;
  logic [7:0]       hdr_unit;
  logic [7:0]       hdr_fc;
  logic [7:0]       hdr_coe;
  logic             hdr_last;
  logic             load_header;
  logic             clr_done;
  logic             write_ok;
  logic             data_last;
  logic             data_two;

  assign clr_done  = (clr_cnt == AW'(IMAGE_WORDS - 1));
  assign write_ok  = (int'(write_index) < IMAGE_WORDS);
  assign data_last = (rem <= QTY_W'(2));
  assign data_two  = (rem >= QTY_W'(2));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && command == CMD_REQUEST_BYTE && frame_end && frame_complete) begin
          state_next = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        state_next = verdict.drop ? ST_IDLE : ST_HEADER;
      end
      ST_HEADER: begin
        if (out_ready) state_next = hdr_last ? ST_IDLE : ST_DATA;
      end
      ST_DATA: begin
        if (out_ready && data_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    load_header = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && command == CMD_WRITE_WORD && write_ok) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(write_index);
          ram_wdata = write_value;
        end
      end
      ST_JUDGE: begin
        load_header = !verdict.drop;
      end
      ST_HEADER: begin
        out_valid = 1'b1;
        ram_re    = out_ready && !hdr_last;
      end
      ST_DATA: begin
        out_valid = 1'b1;
        ram_re    = out_ready && !data_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // The second word of a pair never addresses past the image.
  assign ram_raddr0 = rd_idx;
  assign ram_raddr1 = (rd_idx == AW'(IMAGE_WORDS - 1)) ? '0 : AW'(rd_idx + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= AW'(clr_cnt + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_header) begin
      hdr_tid  <= verdict.tid;
      hdr_unit <= verdict.unit_id;
      rd_idx   <= start_idx;
      rem      <= verdict.qty;
      if (verdict.bad_function || verdict.bad_address) begin
        hdr_len  <= MBAP_LEN_EXC;
        hdr_fc   <= verdict.fc | FC_EXC_FLAG;
        hdr_coe  <= verdict.bad_function ? EXC_BAD_FUNCTION : EXC_BAD_ADDRESS;
        hdr_last <= 1'b1;
      end else begin
        hdr_len  <= MBAP_LEN_EXC + {verdict.qty, 1'b0};
        hdr_fc   <= FC_READ_HOLDING;
        hdr_coe  <= {verdict.qty, 1'b0};
        hdr_last <= 1'b0;
      end
    end else if (ram_re) begin
      rd_idx <= AW'(rd_idx + 2'd2);
      if (state == ST_DATA) rem <= rem - QTY_W'(2);
    end
  end

  assign is_header          = (state == ST_HEADER);
  assign trans_id           = is_header ? hdr_tid : '0;
  assign mbap_length        = is_header ? hdr_len : '0;
  assign unit_id            = is_header ? hdr_unit : '0;
  assign function_code      = is_header ? hdr_fc : '0;
  assign count_or_exception = is_header ? hdr_coe : '0;
  assign word_first         = is_header ? '0 : ram_rdata0;
  assign word_second        = (is_header || !data_two) ? '0 : ram_rdata1;
  assign words_valid        = is_header ? 2'd0 : (data_two ? 2'd2 : 2'd1);
  assign last               = is_header ? hdr_last : data_last;

endmodule

[rtl/modbus_tcp_read_register_responder_unit.sv]
// Top level of the Modbus TCP Read Holding Registers responder.
//
// Requests enter on the in channel (in_valid/in_ready). With command low a
// request carries one received frame byte, with frame_end on the last byte;
// with command high it writes write_value into image word write_index.
// Responses leave on the out channel (out_valid/out_ready): one header item,
// then for a good read one data item per two register words. base_address
// is written on the cfg channel, which is always ready.
//
// After the frame-end byte is accepted, the frame is checked in the judge
// state and the header is then offered; data items follow at one per
// cycle while out_ready stays high, each read from the image memory at the
// edge where the item before it is taken. The in channel stays blocked
// from the frame-end byte until the last response item is taken, so a
// stalled receiver holds the whole block.
//
// After reset the image memory is cleared one word per cycle while
// in_ready stays low; base_address returns to 40000 and a partly
// received frame is discarded.
module modbus_tcp_read_register_responder_unit import mbtr_pkg::*; #(
  parameter int IMAGE_WORDS = 256,
  parameter int MAX_QUANTITY = 125
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  request_byte,
  input  logic        frame_end,
  input  logic [7:0]  write_index,
  input  logic [15:0] write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_header,
  output logic [15:0] trans_id,
  output logic [7:0]  mbap_length,
  output logic [7:0]  unit_id,
  output logic [7:0]  function_code,
  output logic [7:0]  count_or_exception,
  output logic [15:0] word_first,
  output logic [15:0] word_second,
  output logic [1:0]  words_valid,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(IMAGE_WORDS);

  logic [15:0]       base_address;
  logic [16:0]       base_end;
  logic              byte_accept;
  logic              frame_complete;
  verdict_t          verdict;
  logic [AW-1:0]     start_idx;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr0;
  logic [AW-1:0]     ram_raddr1;
  logic [WORD_W-1:0] ram_rdata0;
  logic [WORD_W-1:0] ram_rdata1;

  // The configuration register can be written at any time; the end of the
  // image window is kept alongside it so the range check needs one add.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_ADDRESS_RESET;
      base_end     <= {1'b0, BASE_ADDRESS_RESET} + 17'(IMAGE_WORDS);
    end else if (cfg_valid && cfg_ready) begin
      base_address <= cfg_data;
      base_end     <= {1'b0, cfg_data} + 17'(IMAGE_WORDS);
    end
  end

  assign byte_accept = in_valid && in_ready && (command == CMD_REQUEST_BYTE);

  mbtr_frame_judge #(
    .IMAGE_WORDS  (IMAGE_WORDS),
    .MAX_QUANTITY (MAX_QUANTITY)
  ) u_judge (
    .clk            (clk),
    .rst            (rst),
    .byte_accept    (byte_accept),
    .request_byte   (request_byte),
    .frame_end      (frame_end),
    .base_address   (base_address),
    .base_end       (base_end),
    .frame_complete (frame_complete),
    .verdict        (verdict),
    .start_idx      (start_idx)
  );

  mbtr_image_ram #(
    .DEPTH (IMAGE_WORDS)
  ) u_image (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (ram_re),
    .raddr0 (ram_raddr0),
    .raddr1 (ram_raddr1),
    .rdata0 (ram_rdata0),
    .rdata1 (ram_rdata1)
  );

  mbtr_ctrl #(
    .IMAGE_WORDS (IMAGE_WORDS)
  ) u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .command            (command),
    .frame_end          (frame_end),
    .write_index        (write_index),
    .write_value        (write_value),
    .frame_complete     (frame_complete),
    .verdict            (verdict),
    .start_idx          (start_idx),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .is_header          (is_header),
    .trans_id           (trans_id),
    .mbap_length        (mbap_length),
    .unit_id            (unit_id),
    .function_code      (function_code),
    .count_or_exception (count_or_exception),
    .word_first         (word_first),
    .word_second        (word_second),
    .words_valid        (words_valid),
    .last               (last),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_re             (ram_re),
    .ram_raddr0         (ram_raddr0),
    .ram_raddr1         (ram_raddr1),
    .ram_rdata0         (ram_rdata0),
    .ram_rdata1         (ram_rdata1)
  );

  // Requests are never taken while a response is being offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request accepted while a response item is pending");

  // A taken header that is not final is followed at once by a data item.
  a_data_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && is_header && !last |=> out_valid && !is_header)
    else $error("data item missing after a non-final header");

  // A data item carries one or two words.
  a_words_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_header |-> words_valid == 2'd1 || words_valid == 2'd2)
    else $error("data item with no valid word count");

  // A good header's MBAP length is the byte count plus three.
  a_mbap_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_header && !function_code[7] |->
      mbap_length == count_or_exception + MBAP_LEN_EXC)
    else $error("MBAP length does not match byte count");

endmodule

[bench/modbus_tcp_read_register_responder_unit_tb.sv]
// Self-checking testbench for the Modbus TCP read register responder unit.
`timescale 1ns / 100ps

module modbus_tcp_read_register_responder_unit_tb import mbtr_pkg::*; ();

  localparam int IMAGE_WORDS  = 256;
  localparam int MAX_QUANTITY = 125;

  // Cycles allowed after the last response for a frame that gives no reply
  // to be judged.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  // The long receiver hold-off that backs the block up into its input.
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_LIMIT  = 10;
  localparam int RESET_PHASE_REQUESTS = 26;
  localparam int PHASE_REQUESTS       = 16;
  localparam logic [15:0] MBAP_LEN_FIELD = 16'd6;
  // Timeout in ns at a 20 ns clock period, several times the slowest legal run.
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  // One request on the input channel.
  typedef struct packed {
    logic        command;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic [7:0]  write_index;
    logic [15:0] write_value;
  } req_item_t;

  // One response item, in the order of the output ports.
  typedef struct packed {
    logic        is_header;
    logic [15:0] trans_id;
    logic [7:0]  mbap_length;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [7:0]  count_or_exception;
    logic [15:0] word_first;
    logic [15:0] word_second;
    logic [1:0]  words_valid;
    logic        last;
  } reply_t;

  typedef enum {ROW_WRITE, ROW_FRAME} row_kind_t;
  // How the expected reply of a directed row is obtained: from the
  // predictor, or typed straight into the table.
  typedef enum {FROM_MODEL, NO_REPLY, REPLY_BAD_FUNCTION, REPLY_BAD_ADDRESS} row_outcome_t;

  typedef struct {
    row_kind_t    kind;
    int           nbytes;
    logic [15:0]  tid;
    logic [15:0]  proto;
    logic [7:0]   unit;
    logic [7:0]   fc;
    logic [15:0]  start;
    logic [15:0]  qty;
    logic [7:0]   widx;
    logic [15:0]  wval;
    row_outcome_t outcome;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [7:0]  request_byte;
  logic        frame_end;
  logic [7:0]  write_index;
  logic [15:0] write_value;
  logic        out_valid;
  logic        out_ready;
  logic        is_header;
  logic [15:0] trans_id;
  logic [7:0]  mbap_length;
  logic [7:0]  unit_id;
  logic [7:0]  function_code;
  logic [7:0]  count_or_exception;
  logic [15:0] word_first;
  logic [15:0] word_second;
  logic [1:0]  words_valid;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  modbus_tcp_read_register_responder_unit #(
    .IMAGE_WORDS(IMAGE_WORDS),
    .MAX_QUANTITY(MAX_QUANTITY)
  ) dut (.*);

  // Mirror of the block's state, advanced at every accepted request.
  logic [15:0] image_copy [IMAGE_WORDS];
  logic [7:0]  kept_bytes [FRAME_KEEP];
  int          kept_count;
  logic [15:0] base_copy;

  // Response items still owed by the block, oldest first.
  reply_t replies_due [$];

  // Both sides run without gaps while calm is set. hold_out asks the
  // receiver for one long hold-off.
  bit calm;
  bit hold_out;

  int mismatches;
  int requests_sent;
  int frames_sent;
  int writes_sent;
  int items_checked;
  int base_settings;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic string show(input reply_t r);
    return $sformatf("hdr=%0d tid=%h len=%0d unit=%h fc=%h coe=%0d w0=%h w1=%h nw=%0d last=%0d",
                     r.is_header, r.trans_id, r.mbap_length, r.unit_id, r.function_code,
                     r.count_or_exception, r.word_first, r.word_second, r.words_valid,
                     r.last);
  endfunction

  // An exception reply is a single header item carrying the request's
  // function code with the exception flag set.
  function automatic reply_t exc_reply(input logic [15:0] tid, input logic [7:0] unit,
                                       input logic [7:0] fc, input logic [7:0] code);
    reply_t r;
    r = '0;
    r.is_header = 1'b1;
    r.trans_id = tid;
    r.mbap_length = MBAP_LEN_EXC;
    r.unit_id = unit;
    r.function_code = fc | FC_EXC_FLAG;
    r.count_or_exception = code;
    r.last = 1'b1;
    return r;
  endfunction

  // An image write with random content; the byte and frame end fields
  // must be ignored by the block.
  function automatic req_item_t any_write();
    req_item_t it;
    it.command = CMD_WRITE_WORD;
    it.rx_byte = 8'($urandom);
    it.frame_end = 1'($urandom);
    it.write_index = 8'($urandom);
    it.write_value = 16'($urandom);
    return it;
  endfunction

  function automatic plan_row_t frame_row(input int nbytes, input logic [15:0] tid,
                                          input logic [15:0] proto, input logic [7:0] unit,
                                          input logic [7:0] fc, input logic [15:0] start,
                                          input logic [15:0] qty, input row_outcome_t outcome);
    plan_row_t row;
    row.kind = ROW_FRAME;
    row.nbytes = nbytes;
    row.tid = tid;
    row.proto = proto;
    row.unit = unit;
    row.fc = fc;
    row.start = start;
    row.qty = qty;
    row.widx = '0;
    row.wval = '0;
    row.outcome = outcome;
    return row;
  endfunction

  function automatic plan_row_t write_row(input logic [7:0] widx, input logic [15:0] wval);
    plan_row_t row;
    row = frame_row(0, '0, '0, '0, '0, '0, '0, FROM_MODEL);
    row.kind = ROW_WRITE;
    row.widx = widx;
    row.wval = wval;
    return row;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
  endtask

  // Predictor: advances the mirrored state by one accepted request and,
  // when keep is set, queues the response items that it causes.
  task automatic serve_request(input req_item_t it, input bit keep);
    logic [15:0] tid;
    logic [15:0] proto;
    logic [7:0]  unit;
    logic [7:0]  fc;
    int          start_i;
    int          qty_i;
    int          offset;
    int          pairs;
    int          w0;
    reply_t      r;

    if (it.command == CMD_WRITE_WORD) begin
      if (int'(it.write_index) < IMAGE_WORDS) image_copy[it.write_index] = it.write_value;
      return;
    end

    // Only the MBAP header and the read PDU are kept; longer frames spill.
    if (kept_count < FRAME_KEEP) begin
      kept_bytes[kept_count] = it.rx_byte;
      kept_count++;
    end
    if (!it.frame_end) return;

    // A frame is judged at its last byte, and the byte count starts over
    // whatever the outcome. Short frames vanish silently.
    if (kept_count < FRAME_KEEP) begin
      kept_count = 0;
      return;
    end
    kept_count = 0;
    if (!keep) return;

    tid   = {kept_bytes[0], kept_bytes[1]};
    proto = {kept_bytes[2], kept_bytes[3]};
    unit  = kept_bytes[6];
    fc    = kept_bytes[7];
    if (proto != 16'h0000) return;

    if (fc != FC_READ_HOLDING) begin
      replies_due.push_back(exc_reply(tid, unit, fc, EXC_BAD_FUNCTION));
      return;
    end

    start_i = int'({kept_bytes[8], kept_bytes[9]});
    qty_i   = int'({kept_bytes[10], kept_bytes[11]});
    // The range test is done in full integer width, so a start near the top
    // of the address space cannot wrap back into the image.
    if (qty_i == 0 || qty_i > MAX_QUANTITY || start_i < int'(base_copy) ||
        start_i + qty_i > int'(base_copy) + IMAGE_WORDS) begin
      replies_due.push_back(exc_reply(tid, unit, fc, EXC_BAD_ADDRESS));
      return;
    end

    r = '0;
    r.is_header = 1'b1;
    r.trans_id = tid;
    r.mbap_length = MBAP_LEN_EXC + 8'(2 * qty_i);
    r.unit_id = unit;
    r.function_code = FC_READ_HOLDING;
    r.count_or_exception = 8'(2 * qty_i);
    replies_due.push_back(r);

    // Register words follow two to an item; an odd count ends on a single.
    offset = start_i - int'(base_copy);
    pairs = (qty_i + 1) / 2;
    for (int k = 0; k < pairs; k++) begin
      r = '0;
      w0 = offset + 2 * k;
      r.word_first = image_copy[w0];
      if (2 * k + 1 < qty_i) begin
        r.word_second = image_copy[w0 + 1];
        r.words_valid = 2'd2;
      end else begin
        r.words_valid = 2'd1;
      end
      r.last = (k == pairs - 1);
      replies_due.push_back(r);
    end
  endtask

  // Offers one request from a falling edge and returns at the rising edge
  // where it is taken. With no gap, valid simply stays high into the next
  // request.
  task automatic send_item(input req_item_t it, input bit keep);
    int gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command = it.command;
    request_byte = it.rx_byte;
    frame_end = it.frame_end;
    write_index = it.write_index;
    write_value = it.write_value;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    if (it.command == CMD_WRITE_WORD) writes_sent++;
    serve_request(it, keep);
  endtask

  // Sends one frame byte by byte. Bytes past the twelfth are random, as
  // are the write fields that a byte request must ignore. With mixed set,
  // image writes are now and then slipped in between the bytes.
  task automatic send_frame(input int nbytes, input logic [15:0] tid,
                            input logic [15:0] proto, input logic [15:0] len_field,
                            input logic [7:0] unit, input logic [7:0] fc,
                            input logic [15:0] start, input logic [15:0] qty,
                            input bit keep, input bit mixed);
    logic [7:0] head [FRAME_KEEP];
    req_item_t  it;
    head = '{tid[15:8], tid[7:0], proto[15:8], proto[7:0], len_field[15:8], len_field[7:0],
             unit, fc, start[15:8], start[7:0], qty[15:8], qty[7:0]};
    for (int i = 0; i < nbytes; i++) begin
      if (mixed && $urandom_range(0, 19) == 0) send_item(any_write(), 1'b1);
      it.command = CMD_REQUEST_BYTE;
      it.rx_byte = (i < FRAME_KEEP) ? head[i] : 8'($urandom);
      it.frame_end = (i == nbytes - 1);
      it.write_index = 8'($urandom);
      it.write_value = 16'($urandom);
      send_item(it, keep);
    end
    frames_sent++;
  endtask

  // Mostly well-formed reads inside the image, with bad protocol ids, bad
  // function codes, bad quantities, out-of-range starts, short and long
  // frames mixed in.
  task automatic random_frame();
    int          roll;
    int          nbytes;
    int          span;
    int          lo;
    int          hi;
    logic [15:0] proto;
    logic [15:0] len_field;
    logic [15:0] start;
    logic [15:0] qty;
    logic [7:0]  fc;

    roll = $urandom_range(0, 99);
    if (roll < 80) nbytes = FRAME_KEEP;
    else if (roll < 90) nbytes = $urandom_range(FRAME_KEEP + 1, 20);
    else nbytes = $urandom_range(1, FRAME_KEEP - 1);

    proto = ($urandom_range(0, 99) < 8) ? 16'($urandom_range(1, 65535)) : 16'h0000;
    fc = ($urandom_range(0, 99) < 12) ? 8'($urandom) : FC_READ_HOLDING;
    len_field = ($urandom_range(0, 3) == 0) ? 16'($urandom) : MBAP_LEN_FIELD;

    roll = $urandom_range(0, 99);
    if (roll < 70) qty = 16'($urandom_range(1, 8));
    else if (roll < 85) qty = 16'($urandom_range(9, MAX_QUANTITY));
    else if (roll < 92) qty = 16'(MAX_QUANTITY);
    else if (roll < 95) qty = 16'h0000;
    else qty = 16'($urandom_range(MAX_QUANTITY + 1, 65535));

    // Most starts leave room for the whole read inside the image.
    span = (qty >= 1 && qty <= MAX_QUANTITY) ? int'(qty) : 1;
    lo = int'(base_copy);
    hi = lo + IMAGE_WORDS - span;
    if (hi > 65535) hi = 65535;
    roll = $urandom_range(0, 99);
    if (roll < 85) start = 16'($urandom_range(hi, lo));
    else if (roll < 92) start = base_copy - 16'd1;
    else start = 16'($urandom);

    send_frame(nbytes, 16'($urandom), proto, len_field, 8'($urandom), fc, start, qty,
               1'b1, 1'b1);
  endtask

  task automatic run_random(input int quota);
    int stop_at;
    stop_at = requests_sent + quota;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 99) < 22) send_item(any_write(), 1'b1);
      else random_frame();
    end
  endtask

  // Drops valid and waits until every owed item is out and any frame that
  // gives no reply has been judged.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_base(input logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    base_copy = value;
    base_settings++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off on request, and stretches
  // without stalls while calm is set.
  initial begin : out_side
    int stall;
    bit held;
    out_ready = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out && !held) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end
      stall = calm ? 0 : pick_gap();
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // Every item taken from the block is matched against the oldest owed one.
  always @(posedge clk) begin : check_replies
    reply_t got;
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      got = {is_header, trans_id, mbap_length, unit_id, function_code, count_or_exception,
             word_first, word_second, words_valid, last};
      items_checked++;
      if (replies_due.size() == 0) begin
        flag({"response item with nothing owed: ", show(got)});
      end else begin
        want = replies_due.pop_front();
        if (got !== want)
          flag({"response item differs\n  expected ", show(want), "\n  actual   ", show(got)});
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    plan_row_t   plan [$];
    req_item_t   it;
    logic [15:0] base_plan [5];

    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_REQUEST_BYTE;
    request_byte = '0;
    frame_end = 1'b0;
    write_index = '0;
    write_value = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    hold_out = 1'b0;

    foreach (image_copy[i]) image_copy[i] = '0;
    foreach (kept_bytes[i]) kept_bytes[i] = '0;
    kept_count = 0;
    base_copy = BASE_ADDRESS_RESET;

    // Directed table, walked with the reset value of base_address. A read
    // right after reset sees the cleared image; exceptions and dropped
    // frames have their outcome written in the table.
    plan.push_back(frame_row(12, 16'h0000, 16'h0000, 8'h00, 8'h03, 16'd40000, 16'd1,
                             FROM_MODEL));
    plan.push_back(write_row(8'd0, 16'h8001));
    plan.push_back(write_row(8'd255, 16'hFFFF));
    plan.push_back(write_row(8'd128, 16'h7FFE));
    plan.push_back(frame_row(12, 16'hFFFF, 16'h0000, 8'hFF, 8'h03, 16'd40000, 16'd2,
                             FROM_MODEL));
    plan.push_back(frame_row(12, 16'h1234, 16'h0000, 8'h01, 8'h03, 16'd40255, 16'd1,
                             FROM_MODEL));
    plan.push_back(frame_row(12, 16'h5A5A, 16'h0000, 8'h11, 8'h03, 16'd40131, 16'd125,
                             FROM_MODEL));
    plan.push_back(frame_row(12, 16'h0001, 16'h0000, 8'h02, 8'h03, 16'd40000, 16'd0,
                             REPLY_BAD_ADDRESS));
    plan.push_back(frame_row(12, 16'h0002, 16'h0000, 8'h02, 8'h03, 16'd40000, 16'd126,
                             REPLY_BAD_ADDRESS));
    plan.push_back(frame_row(12, 16'h0003, 16'h0000, 8'h02, 8'h03, 16'd39999, 16'd1,
                             REPLY_BAD_ADDRESS));
    plan.push_back(frame_row(12, 16'h0004, 16'h0000, 8'h02, 8'h03, 16'd40200, 16'd57,
                             REPLY_BAD_ADDRESS));
    plan.push_back(frame_row(12, 16'h0005, 16'h0000, 8'h02, 8'h03, 16'd65535, 16'd125,
                             REPLY_BAD_ADDRESS));
    plan.push_back(frame_row(12, 16'h0006, 16'h0000, 8'h03, 8'h04, 16'd40000, 16'd1,
                             REPLY_BAD_FUNCTION));
    plan.push_back(frame_row(12, 16'h0007, 16'h0000, 8'h03, 8'h00, 16'd40000, 16'd1,
                             REPLY_BAD_FUNCTION));
    plan.push_back(frame_row(12, 16'h0008, 16'h0000, 8'h03, 8'hFF, 16'd40000, 16'd1,
                             REPLY_BAD_FUNCTION));
    plan.push_back(frame_row(12, 16'h0009, 16'h0000, 8'h03, 8'h83, 16'd40000, 16'd1,
                             REPLY_BAD_FUNCTION));
    plan.push_back(frame_row(12, 16'h000A, 16'h0001, 8'h04, 8'h03, 16'd40000, 16'd1,
                             NO_REPLY));
    plan.push_back(frame_row(12, 16'h000B, 16'h8000, 8'h04, 8'h04, 16'd40000, 16'd1,
                             NO_REPLY));
    plan.push_back(frame_row(11, 16'h000C, 16'h0000, 8'h05, 8'h03, 16'd40000, 16'd1,
                             NO_REPLY));
    plan.push_back(frame_row(1, 16'h000D, 16'h0000, 8'h05, 8'h03, 16'd40000, 16'd1,
                             NO_REPLY));
    // A long frame right after a short one: the count must have started over.
    plan.push_back(frame_row(20, 16'hA5C3, 16'h0000, 8'h06, 8'h03, 16'd40254, 16'd2,
                             FROM_MODEL));
    plan.push_back(frame_row(12, 16'h3C5A, 16'h0000, 8'h07, 8'h03, 16'd40001, 16'd3,
                             FROM_MODEL));

    // Base address settings for the later phases: both extremes, the reset
    // value written back explicitly, and two random ones.
    base_plan[0] = 16'h0000;
    base_plan[1] = 16'hFFFF;
    base_plan[2] = BASE_ADDRESS_RESET;
    base_plan[3] = 16'($urandom);
    base_plan[4] = 16'($urandom);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        it = '0;
        it.command = CMD_WRITE_WORD;
        it.write_index = plan[i].widx;
        it.write_value = plan[i].wval;
        send_item(it, 1'b1);
      end else begin
        send_frame(plan[i].nbytes, plan[i].tid, plan[i].proto, MBAP_LEN_FIELD, plan[i].unit,
                   plan[i].fc, plan[i].start, plan[i].qty, plan[i].outcome == FROM_MODEL,
                   1'b0);
        // The last byte was taken in this time step, well before the reply.
        case (plan[i].outcome)
          REPLY_BAD_FUNCTION: begin
            replies_due.push_back(exc_reply(plan[i].tid, plan[i].unit, plan[i].fc,
                                            EXC_BAD_FUNCTION));
          end
          REPLY_BAD_ADDRESS: begin
            replies_due.push_back(exc_reply(plan[i].tid, plan[i].unit, plan[i].fc,
                                            EXC_BAD_ADDRESS));
          end
          default: begin
          end
        endcase
      end
    end

    run_random(RESET_PHASE_REQUESTS);

    // Each phase ends on a whole frame, so base_address only changes with
    // the block idle and no frame half received.
    foreach (base_plan[p]) begin
      wait_idle();
      set_base(base_plan[p]);
      // The first phase opens with the receiver held off while requests
      // keep coming, so the block fills and blocks its input.
      hold_out = (p == 0);
      calm = (p == 2);
      run_random(PHASE_REQUESTS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d frames and %0d image writes, %0d response items.",
             requests_sent, frames_sent, writes_sent, items_checked);
    $display("Base address took %0d written values plus its reset value; %0d mismatches.",
             base_settings, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mbtr_pkg.sv
rtl/mbtr_image_ram.sv
rtl/mbtr_frame_judge.sv
rtl/mbtr_ctrl.sv
rtl/modbus_tcp_read_register_responder_unit.sv
bench/modbus_tcp_read_register_responder_unit_tb.sv
